[rtl/timer_deadline_heap_assert.svh]
// Assertion macros used by the checker file tdh_checker.sv.
`ifndef TIMER_DEADLINE_HEAP_ASSERT_SVH
`define TIMER_DEADLINE_HEAP_ASSERT_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define TDH_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("timer heap check failed");

// Next-cycle implication, sampled on clock, off during reset.
`define TDH_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("timer heap check failed");

`endif

[rtl/tdh_pkg.sv]
package tdh_pkg;

   localparam int MAX_TIMERS = 16;
   localparam int IDX_W      = $clog2(MAX_TIMERS);
   localparam int NUM_W      = IDX_W + 1;
   localparam int CNT_W      = 16;
   localparam int CMD_W      = 3;
   localparam int STAT_W     = 2;

   // Command codes
   localparam logic [CMD_W-1:0] CMD_TICK  = 3'd0;
   localparam logic [CMD_W-1:0] CMD_ALLOC = 3'd1;
   localparam logic [CMD_W-1:0] CMD_ARM   = 3'd2;
   localparam logic [CMD_W-1:0] CMD_STOP  = 3'd3;
   localparam logic [CMD_W-1:0] CMD_READ  = 3'd4;

   // Result status codes
   localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
   localparam logic [STAT_W-1:0] STAT_NOFREE = 2'd1;
   localparam logic [STAT_W-1:0] STAT_BAD    = 2'd2;

   // Slot states
   localparam logic [1:0] SLOT_FREE    = 2'd0;
   localparam logic [1:0] SLOT_STOPPED = 2'd1;
   localparam logic [1:0] SLOT_RUNNING = 2'd2;

   // Heap unit operations
   localparam logic [2:0] HOP_PEEK    = 3'd0;
   localparam logic [2:0] HOP_PUSH    = 3'd1;
   localparam logic [2:0] HOP_POP     = 3'd2;
   localparam logic [2:0] HOP_REPLACE = 3'd3;
   localparam logic [2:0] HOP_REMOVE  = 3'd4;

   typedef struct packed {
      logic [IDX_W-1:0] id;
      logic [CNT_W-1:0] key;
   } entry_type;

   typedef struct packed {
      logic       start;
      logic [2:0] op;
      logic       sel;
      entry_type  entry;
   } heap_req_type;

   typedef struct packed {
      logic      done;
      logic      found;
      entry_type root;
   } heap_rsp_type;

   // Left child of a heap position
   function automatic logic [NUM_W:0] left_child(input logic [IDX_W-1:0] idx);
      left_child = {1'b0, idx, 1'b1};
   endfunction

endpackage

[rtl/tdh_heap.sv]
module tdh_heap (
   input  logic                 clock,
   input  logic                 reset,
   input  tdh_pkg::heap_req_type heap_req,
   output tdh_pkg::heap_rsp_type heap_rsp
);
   import tdh_pkg::*;

   localparam logic [3:0] H_IDLE   = 4'd0;
   localparam logic [3:0] H_PEEK_W = 4'd1;
   localparam logic [3:0] H_UP     = 4'd2;
   localparam logic [3:0] H_UP_CMP = 4'd3;
   localparam logic [3:0] H_POP    = 4'd4;
   localparam logic [3:0] H_POP_W  = 4'd5;
   localparam logic [3:0] H_DN_L   = 4'd6;
   localparam logic [3:0] H_DN_R   = 4'd7;
   localparam logic [3:0] H_DN_CMP = 4'd8;
   localparam logic [3:0] H_SCAN   = 4'd9;
   localparam logic [3:0] H_LIFT   = 4'd10;
   localparam logic [3:0] H_LIFT_W = 4'd11;
   localparam logic [3:0] H_DONE   = 4'd12;

   // both heaps share one memory, heap select is the top address bit
   entry_type heap_mem_ff [0:2*MAX_TIMERS-1];
   entry_type rdata_ff;

   logic [3:0]       hst_ff, hst_in;
   logic             sel_ff, sel_in;
   entry_type        e_ff, e_in;
   entry_type        l_ff, l_in;
   logic             have_r_ff, have_r_in;
   logic             found_ff, found_in;
   logic [NUM_W-1:0] n_ff, n_in;
   logic [IDX_W-1:0] i_ff, i_in;
   logic [IDX_W-1:0] tgt_ff, tgt_in;
   logic [NUM_W-1:0] cnt_a_ff, cnt_b_ff;

   logic             mem_we, mem_re;
   logic [IDX_W:0]   mem_waddr, mem_raddr;
   entry_type        mem_wdata;
   logic             cnt_we, cnt_wsel;
   logic [NUM_W-1:0] cnt_wval, cnt_req;
   logic [IDX_W-1:0] parent;
   logic [NUM_W:0]   l_idx, r_idx, n_ext;
   logic             use_r;
   entry_type        son;
   logic [IDX_W-1:0] son_idx;

   assign parent  = (i_ff - 1'b1) >> 1;
   assign l_idx   = left_child(i_ff);
   assign r_idx   = l_idx + 1'b1;
   assign n_ext   = {1'b0, n_ff};
   assign cnt_req = heap_req.sel ? cnt_b_ff : cnt_a_ff;
   assign use_r   = have_r_ff && (rdata_ff.key < l_ff.key);
   assign son     = use_r ? rdata_ff : l_ff;
   assign son_idx = use_r ? r_idx[IDX_W-1:0] : l_idx[IDX_W-1:0];

   // sequence one heap operation over the single-port memory
   always_comb begin
      hst_in    = hst_ff;
      sel_in    = sel_ff;
      e_in      = e_ff;
      l_in      = l_ff;
      have_r_in = have_r_ff;
      found_in  = found_ff;
      n_in      = n_ff;
      i_in      = i_ff;
      tgt_in    = tgt_ff;
      mem_we    = 1'b0;
      mem_re    = 1'b0;
      mem_waddr = {sel_ff, i_ff};
      mem_raddr = {sel_ff, i_ff};
      mem_wdata = e_ff;
      cnt_we    = 1'b0;
      cnt_wsel  = sel_ff;
      cnt_wval  = n_ff;
      heap_rsp.done  = 1'b0;
      heap_rsp.found = found_ff;
      heap_rsp.root  = rdata_ff;
      case (hst_ff)
         H_IDLE: begin
            if (heap_req.start) begin
               sel_in   = heap_req.sel;
               e_in     = heap_req.entry;
               tgt_in   = heap_req.entry.id;
               n_in     = cnt_req;
               found_in = 1'b0;
               i_in     = '0;
               case (heap_req.op)
                  HOP_PEEK: begin
                     if (cnt_req == '0) begin
                        hst_in = H_DONE;
                     end else begin
                        mem_re    = 1'b1;
                        mem_raddr = {heap_req.sel, {IDX_W{1'b0}}};
                        hst_in    = H_PEEK_W;
                     end
                  end
                  HOP_PUSH: begin
                     if (cnt_req >= NUM_W'(MAX_TIMERS)) begin
                        hst_in = H_DONE;
                     end else begin
                        i_in     = cnt_req[IDX_W-1:0];
                        n_in     = cnt_req + 1'b1;
                        cnt_we   = 1'b1;
                        cnt_wsel = heap_req.sel;
                        cnt_wval = cnt_req + 1'b1;
                        hst_in   = H_UP;
                     end
                  end
                  HOP_POP: begin
                     if (cnt_req == '0) hst_in = H_DONE;
                     else hst_in = H_POP;
                  end
                  HOP_REPLACE: begin
                     hst_in = H_DN_L;
                  end
                  HOP_REMOVE: begin
                     if (cnt_req == '0) begin
                        hst_in = H_DONE;
                     end else begin
                        mem_re    = 1'b1;
                        mem_raddr = {heap_req.sel, {IDX_W{1'b0}}};
                        hst_in    = H_SCAN;
                     end
                  end
                  default: begin
                     hst_in = H_DONE;
                  end
               endcase
            end
         end
         // nothing to walk: report done in the cycle after start
         H_DONE: begin
            heap_rsp.done = 1'b1;
            hst_in        = H_IDLE;
         end
         H_PEEK_W: begin
            heap_rsp.done  = 1'b1;
            heap_rsp.found = 1'b1;
            hst_in         = H_IDLE;
         end
         // bubble the held entry up toward the root
         H_UP: begin
            if (i_ff == '0) begin
               mem_we        = 1'b1;
               heap_rsp.done = 1'b1;
               hst_in        = H_IDLE;
            end else begin
               mem_re    = 1'b1;
               mem_raddr = {sel_ff, parent};
               hst_in    = H_UP_CMP;
            end
         end
         H_UP_CMP: begin
            mem_we = 1'b1;
            if (rdata_ff.key > e_ff.key) begin
               mem_wdata = rdata_ff;
               i_in      = parent;
               hst_in    = H_UP;
            end else begin
               heap_rsp.done = 1'b1;
               hst_in        = H_IDLE;
            end
         end
         // drop one entry, move the last one to the root
         H_POP: begin
            n_in     = n_ff - 1'b1;
            cnt_we   = 1'b1;
            cnt_wval = n_ff - 1'b1;
            if (n_ff == NUM_W'(1)) begin
               heap_rsp.done = 1'b1;
               hst_in        = H_IDLE;
            end else begin
               mem_re    = 1'b1;
               mem_raddr = {sel_ff, IDX_W'(n_ff - 1'b1)};
               hst_in    = H_POP_W;
            end
         end
         H_POP_W: begin
            e_in   = rdata_ff;
            i_in   = '0;
            hst_in = H_DN_L;
         end
         // sift the held entry down: read left, then right child
         H_DN_L: begin
            if (l_idx >= n_ext) begin
               mem_we        = 1'b1;
               heap_rsp.done = 1'b1;
               hst_in        = H_IDLE;
            end else begin
               mem_re    = 1'b1;
               mem_raddr = {sel_ff, l_idx[IDX_W-1:0]};
               hst_in    = H_DN_R;
            end
         end
         H_DN_R: begin
            l_in = rdata_ff;
            if (r_idx < n_ext) begin
               mem_re    = 1'b1;
               mem_raddr = {sel_ff, r_idx[IDX_W-1:0]};
               have_r_in = 1'b1;
            end else begin
               have_r_in = 1'b0;
            end
            hst_in = H_DN_CMP;
         end
         H_DN_CMP: begin
            mem_we = 1'b1;
            if (son.key < e_ff.key) begin
               mem_wdata = son;
               i_in      = son_idx;
               hst_in    = H_DN_L;
            end else begin
               heap_rsp.done = 1'b1;
               hst_in        = H_IDLE;
            end
         end
         // look for the target slot one position a cycle
         H_SCAN: begin
            if (rdata_ff.id == tgt_ff) begin
               found_in = 1'b1;
               hst_in   = H_LIFT;
            end else if (({1'b0, i_ff} + 1'b1) >= n_ff) begin
               heap_rsp.done = 1'b1;
               hst_in        = H_IDLE;
            end else begin
               i_in      = i_ff + 1'b1;
               mem_re    = 1'b1;
               mem_raddr = {sel_ff, IDX_W'(i_ff + 1'b1)};
            end
         end
         // shift the path above the target down by one, then pop the root
         H_LIFT: begin
            if (i_ff == '0) begin
               hst_in = H_POP;
            end else begin
               mem_re    = 1'b1;
               mem_raddr = {sel_ff, parent};
               hst_in    = H_LIFT_W;
            end
         end
         H_LIFT_W: begin
            mem_we    = 1'b1;
            mem_wdata = rdata_ff;
            i_in      = parent;
            hst_in    = H_LIFT;
         end
         default: begin
            hst_in = H_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) heap_mem_ff[mem_waddr] <= mem_wdata;
      if (mem_re) rdata_ff <= heap_mem_ff[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hst_ff   <= H_IDLE;
         cnt_a_ff <= '0;
         cnt_b_ff <= '0;
      end else begin
         hst_ff <= hst_in;
         if (cnt_we && !cnt_wsel) cnt_a_ff <= cnt_wval;
         if (cnt_we && cnt_wsel)  cnt_b_ff <= cnt_wval;
      end
   end

   always_ff @(posedge clock) begin
      sel_ff    <= sel_in;
      e_ff      <= e_in;
      l_ff      <= l_in;
      have_r_ff <= have_r_in;
      found_ff  <= found_in;
      n_ff      <= n_in;
      i_ff      <= i_in;
      tgt_ff    <= tgt_in;
   end

endmodule

[rtl/timer_deadline_heap.sv]
// Soft-timer engine for 16 timer slots on a 16-bit tick counter. Deadlines live
// in two binary min-heaps (this counter epoch and the next) that share one
// single-port heap memory, walked by one heap unit; that memory port sets the
// pace. A command occupies the block from acceptance to its result. Read and
// rejected commands walk no heap; allocate with a delay and arm push and sift
// the entry up; arm or stop of a running timer first scans for its position
// and removes it. A tick peeks the current root and handles each expired timer
// in turn; it gives one result beat per expiry (none when nothing is due). A
// result waits in an output register; the next result loads once it is taken.
module timer_deadline_heap (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [tdh_pkg::CMD_W-1:0]  req_cmd,
   input  logic [tdh_pkg::IDX_W-1:0]  req_timer_id,
   input  logic [tdh_pkg::CNT_W-1:0]  req_delay,
   input  logic [tdh_pkg::CNT_W-1:0]  req_reload,
   input  logic                       req_delete_flag,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [tdh_pkg::STAT_W-1:0] rsp_status,
   output logic [tdh_pkg::IDX_W-1:0]  rsp_result_id,
   output logic [tdh_pkg::CNT_W-1:0]  rsp_remaining,
   output logic                       rsp_expired,
   output logic                       rsp_last
);
   import tdh_pkg::*;

   localparam logic [3:0] S_IDLE      = 4'd0;
   localparam logic [3:0] S_PEEK      = 4'd1;
   localparam logic [3:0] S_PEEK_W    = 4'd2;
   localparam logic [3:0] S_EMIT_MID  = 4'd3;
   localparam logic [3:0] S_EXP       = 4'd4;
   localparam logic [3:0] S_EXP_W     = 4'd5;
   localparam logic [3:0] S_EXP_POP   = 4'd6;
   localparam logic [3:0] S_EXP_POP_W = 4'd7;
   localparam logic [3:0] S_UNARM_C   = 4'd8;
   localparam logic [3:0] S_UNARM_CW  = 4'd9;
   localparam logic [3:0] S_UNARM_F   = 4'd10;
   localparam logic [3:0] S_UNARM_FW  = 4'd11;
   localparam logic [3:0] S_ARM       = 4'd12;
   localparam logic [3:0] S_ARM_W     = 4'd13;
   localparam logic [3:0] S_STOP_FIN  = 4'd14;
   localparam logic [3:0] S_RESP      = 4'd15;

   logic [3:0]        st_ff, st_in;
   logic [IDX_W-1:0]  tid_ff, tid_in;
   logic [CNT_W-1:0]  delay_ff, delay_in;
   logic              del_ff, del_in;
   logic              after_stop_ff, after_stop_in;
   logic [CNT_W-1:0]  tick_ff, tick_in;
   logic              a_cur_ff, a_cur_in;
   logic [1:0]        slot_ff [0:MAX_TIMERS-1];
   logic [CNT_W-1:0]  deadline_ff [0:MAX_TIMERS-1];
   logic [CNT_W-1:0]  reload_mem_ff [0:MAX_TIMERS-1];
   logic [STAT_W-1:0] res_status_ff, res_status_in;
   logic [IDX_W-1:0]  res_id_ff, res_id_in;
   logic [CNT_W-1:0]  res_rem_ff, res_rem_in;
   logic              res_exp_ff, res_exp_in;
   logic              pend_ff, pend_in;
   logic [NUM_W-1:0]  out_cnt_ff, out_cnt_in;
   entry_type         root_ff, root_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [STAT_W-1:0] rsp_status_ff;
   logic [IDX_W-1:0]  rsp_id_ff;
   logic [CNT_W-1:0]  rsp_rem_ff;
   logic              rsp_exp_ff, rsp_last_ff;
   logic              rsp_load, rsp_load_last;

   logic              slot_we;
   logic [IDX_W-1:0]  slot_waddr;
   logic [1:0]        slot_wdata;
   logic              dl_we;
   logic [IDX_W-1:0]  dl_waddr;
   logic [CNT_W-1:0]  dl_wdata;
   logic              rl_we;

   logic              free_any;
   logic [IDX_W-1:0]  free_id;
   logic              cur_sel, fut_sel, out_free, id_ok, id_run;
   logic [CNT_W:0]    arm_sum, exp_sum;
   logic [CNT_W-1:0]  exp_reload;

   heap_req_type      heap_req;
   heap_rsp_type      heap_rsp;

   tdh_heap u_heap (
      .clock    (clock),
      .reset    (reset),
      .heap_req (heap_req),
      .heap_rsp (heap_rsp)
   );

   assign cur_sel    = ~a_cur_ff;
   assign fut_sel    = a_cur_ff;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign id_ok      = slot_ff[req_timer_id] != SLOT_FREE;
   assign id_run     = slot_ff[req_timer_id] == SLOT_RUNNING;
   assign arm_sum    = {1'b0, tick_ff} + {1'b0, delay_ff};
   assign exp_reload = reload_mem_ff[root_ff.id];
   assign exp_sum    = {1'b0, tick_ff} + {1'b0, exp_reload};

   // find the lowest free slot
   always_comb begin
      free_any = 1'b0;
      free_id  = '0;
      for (int k = MAX_TIMERS - 1; k >= 0; k--) begin
         if (slot_ff[k] == SLOT_FREE) begin
            free_any = 1'b1;
            free_id  = IDX_W'(k);
         end
      end
   end

   // command sequencer
   always_comb begin
      st_in         = st_ff;
      tid_in        = tid_ff;
      delay_in      = delay_ff;
      del_in        = del_ff;
      after_stop_in = after_stop_ff;
      tick_in       = tick_ff;
      a_cur_in      = a_cur_ff;
      res_status_in = res_status_ff;
      res_id_in     = res_id_ff;
      res_rem_in    = res_rem_ff;
      res_exp_in    = res_exp_ff;
      pend_in       = pend_ff;
      out_cnt_in    = out_cnt_ff;
      root_in       = root_ff;
      rsp_load      = 1'b0;
      rsp_load_last = 1'b1;
      slot_we       = 1'b0;
      slot_waddr    = tid_ff;
      slot_wdata    = SLOT_RUNNING;
      dl_we         = 1'b0;
      dl_waddr      = tid_ff;
      dl_wdata      = arm_sum[CNT_W-1:0];
      rl_we         = 1'b0;
      heap_req.start = 1'b0;
      heap_req.op    = HOP_PEEK;
      heap_req.sel   = cur_sel;
      heap_req.entry = '{id: tid_ff, key: arm_sum[CNT_W-1:0]};
      case (st_ff)
         S_IDLE: begin
            if (req_valid) begin
               tid_in        = req_timer_id;
               delay_in      = req_delay;
               del_in        = req_delete_flag;
               res_status_in = STAT_BAD;
               res_id_in     = req_timer_id;
               res_rem_in    = '0;
               res_exp_in    = 1'b0;
               st_in         = S_RESP;
               case (req_cmd)
                  CMD_TICK: begin
                     tick_in    = tick_ff + 1'b1;
                     if (tick_ff == {CNT_W{1'b1}}) a_cur_in = ~a_cur_ff;
                     pend_in    = 1'b0;
                     out_cnt_in = '0;
                     st_in      = S_PEEK;
                  end
                  CMD_ALLOC: begin
                     if (!free_any) begin
                        res_status_in = STAT_NOFREE;
                        res_id_in     = '0;
                     end else begin
                        slot_we       = 1'b1;
                        slot_waddr    = free_id;
                        slot_wdata    = SLOT_STOPPED;
                        rl_we         = 1'b1;
                        tid_in        = free_id;
                        res_status_in = STAT_OK;
                        res_id_in     = free_id;
                        if (req_delay != '0) st_in = S_ARM;
                     end
                  end
                  CMD_ARM: begin
                     if (id_ok && req_delay != '0) begin
                        rl_we         = 1'b1;
                        res_status_in = STAT_OK;
                        after_stop_in = 1'b0;
                        st_in         = id_run ? S_UNARM_C : S_ARM;
                     end
                  end
                  CMD_STOP: begin
                     if (id_ok) begin
                        res_status_in = STAT_OK;
                        after_stop_in = 1'b1;
                        st_in         = id_run ? S_UNARM_C : S_STOP_FIN;
                     end
                  end
                  CMD_READ: begin
                     if (id_ok) begin
                        res_status_in = STAT_OK;
                        if (id_run) res_rem_in = deadline_ff[req_timer_id] - tick_ff;
                     end
                  end
                  default: begin
                     res_status_in = STAT_BAD;
                  end
               endcase
            end
         end
         // arm: deadline past the counter top goes to the next epoch
         S_ARM: begin
            dl_we          = 1'b1;
            slot_we        = 1'b1;
            slot_wdata     = SLOT_RUNNING;
            heap_req.start = 1'b1;
            heap_req.op    = HOP_PUSH;
            heap_req.sel   = arm_sum[CNT_W] ? fut_sel : cur_sel;
            st_in          = S_ARM_W;
         end
         S_ARM_W: begin
            if (heap_rsp.done) st_in = S_RESP;
         end
         // take a running timer out of whichever heap holds it
         S_UNARM_C: begin
            heap_req.start = 1'b1;
            heap_req.op    = HOP_REMOVE;
            st_in          = S_UNARM_CW;
         end
         S_UNARM_CW: begin
            if (heap_rsp.done) begin
               if (!heap_rsp.found) st_in = S_UNARM_F;
               else st_in = after_stop_ff ? S_STOP_FIN : S_ARM;
            end
         end
         S_UNARM_F: begin
            heap_req.start = 1'b1;
            heap_req.op    = HOP_REMOVE;
            heap_req.sel   = fut_sel;
            st_in          = S_UNARM_FW;
         end
         S_UNARM_FW: begin
            if (heap_rsp.done) st_in = after_stop_ff ? S_STOP_FIN : S_ARM;
         end
         S_STOP_FIN: begin
            slot_we    = 1'b1;
            slot_wdata = del_ff ? SLOT_FREE : SLOT_STOPPED;
            st_in      = S_RESP;
         end
         // tick: look at the current root
         S_PEEK: begin
            heap_req.start = 1'b1;
            heap_req.op    = HOP_PEEK;
            st_in          = S_PEEK_W;
         end
         S_PEEK_W: begin
            if (heap_rsp.done) begin
               root_in = heap_rsp.root;
               if (heap_rsp.found && heap_rsp.root.key <= tick_ff &&
                   out_cnt_ff < NUM_W'(MAX_TIMERS)) begin
                  st_in = pend_ff ? S_EMIT_MID : S_EXP;
               end else begin
                  st_in = pend_ff ? S_RESP : S_IDLE;
               end
            end
         end
         // another expiry follows, so the held one is not the last beat
         S_EMIT_MID: begin
            if (out_free) begin
               rsp_load      = 1'b1;
               rsp_load_last = 1'b0;
               st_in         = S_EXP;
            end
         end
         // report the root and re-arm or free it
         S_EXP: begin
            pend_in        = 1'b1;
            out_cnt_in     = out_cnt_ff + 1'b1;
            res_status_in  = STAT_OK;
            res_id_in      = root_ff.id;
            res_rem_in     = '0;
            res_exp_in     = 1'b1;
            heap_req.start = 1'b1;
            heap_req.entry = '{id: root_ff.id, key: exp_sum[CNT_W-1:0]};
            if (exp_reload != '0) begin
               dl_we    = 1'b1;
               dl_waddr = root_ff.id;
               dl_wdata = exp_sum[CNT_W-1:0];
               if (exp_sum[CNT_W]) begin
                  heap_req.op  = HOP_PUSH;
                  heap_req.sel = fut_sel;
                  st_in        = S_EXP_W;
               end else begin
                  heap_req.op = HOP_REPLACE;
                  st_in       = S_EXP_POP_W;
               end
            end else begin
               slot_we     = 1'b1;
               slot_waddr  = root_ff.id;
               slot_wdata  = SLOT_FREE;
               heap_req.op = HOP_POP;
               st_in       = S_EXP_POP_W;
            end
         end
         S_EXP_W: begin
            if (heap_rsp.done) st_in = S_EXP_POP;
         end
         S_EXP_POP: begin
            heap_req.start = 1'b1;
            heap_req.op    = HOP_POP;
            st_in          = S_EXP_POP_W;
         end
         S_EXP_POP_W: begin
            if (heap_rsp.done) st_in = S_PEEK;
         end
         S_RESP: begin
            if (out_free) begin
               rsp_load = 1'b1;
               st_in    = S_IDLE;
            end
         end
         default: begin
            st_in = S_IDLE;
         end
      endcase
   end

   // hold the result beat until taken
   assign rsp_valid_in = rsp_load ? 1'b1 : (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= S_IDLE;
         tick_ff      <= '0;
         a_cur_ff     <= 1'b1;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < MAX_TIMERS; k++) slot_ff[k] <= SLOT_FREE;
      end else begin
         st_ff        <= st_in;
         tick_ff      <= tick_in;
         a_cur_ff     <= a_cur_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         if (slot_we) slot_ff[slot_waddr] <= slot_wdata;
      end
   end

   always_ff @(posedge clock) begin
      tid_ff        <= tid_in;
      delay_ff      <= delay_in;
      del_ff        <= del_in;
      after_stop_ff <= after_stop_in;
      res_status_ff <= res_status_in;
      res_id_ff     <= res_id_in;
      res_rem_ff    <= res_rem_in;
      res_exp_ff    <= res_exp_in;
      out_cnt_ff    <= out_cnt_in;
      root_ff       <= root_in;
      if (dl_we) deadline_ff[dl_waddr] <= dl_wdata;
      if (rl_we) reload_mem_ff[tid_in] <= req_reload;
      if (rsp_load) begin
         rsp_status_ff <= res_status_ff;
         rsp_id_ff     <= res_id_ff;
         rsp_rem_ff    <= res_rem_ff;
         rsp_exp_ff    <= res_exp_ff;
         rsp_last_ff   <= rsp_load_last;
      end
   end

   assign req_stall     = st_ff != S_IDLE;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_result_id = rsp_id_ff;
   assign rsp_remaining = rsp_rem_ff;
   assign rsp_expired   = rsp_exp_ff;
   assign rsp_last      = rsp_last_ff;

endmodule

[rtl/tdh_checker.sv]
`include "timer_deadline_heap_assert.svh"

module tdh_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_stall,
   input logic                       rsp_valid,
   input logic                       rsp_stall,
   input logic [tdh_pkg::STAT_W-1:0] rsp_status,
   input logic [tdh_pkg::CNT_W-1:0]  rsp_remaining,
   input logic                       rsp_expired,
   input logic                       rsp_last
);
   import tdh_pkg::*;

   `TDH_ASSERT_NXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid)
   `TDH_ASSERT_NXT(a_busy_after_beat, req_valid && !req_stall, req_stall)
   `TDH_ASSERT_IMP(a_expiry_clean, rsp_valid && rsp_expired, rsp_status == STAT_OK && rsp_remaining == '0)
   `TDH_ASSERT_IMP(a_error_single, rsp_valid && rsp_status != STAT_OK, rsp_last && !rsp_expired)

endmodule

bind timer_deadline_heap tdh_checker u_tdh_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_status    (rsp_status),
   .rsp_remaining (rsp_remaining),
   .rsp_expired   (rsp_expired),
   .rsp_last      (rsp_last)
);

[tb/timer_deadline_heap_tb.sv]
module timer_deadline_heap_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import tdh_pkg::*;

   localparam int CYCLE_LIMIT = 4000000;
   localparam int TICK_MAX    = 65535;

   typedef struct {
      logic [STAT_W-1:0] status;
      logic [IDX_W-1:0]  result_id;
      logic [CNT_W-1:0]  remaining;
      logic              expired;
      logic              last;
   } rsp_beat_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [CMD_W-1:0]    req_cmd = CMD_TICK;
   logic [IDX_W-1:0]    req_timer_id = '0;
   logic [CNT_W-1:0]    req_delay = '0;
   logic [CNT_W-1:0]    req_reload = '0;
   logic                req_delete_flag = 1'b0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [STAT_W-1:0]   rsp_status;
   logic [IDX_W-1:0]    rsp_result_id;
   logic [CNT_W-1:0]    rsp_remaining;
   logic                rsp_expired;
   logic                rsp_last;

   rsp_beat_type        pending_rsp[$];
   int                  sender_idle_pct = 0;
   int                  stall_pct = 0;
   bit                  failed = 1'b0;
   int                  cycle_count = 0;

   // Shadow state of the timer engine
   int                  now_tick;
   logic [IDX_W-1:0]    heap_mem[2][MAX_TIMERS];
   int                  heap_cnt[2];
   int                  cur_heap;
   int                  due_at[MAX_TIMERS];
   logic [1:0]          slot_st[MAX_TIMERS];
   int                  reload_ticks[MAX_TIMERS];

   timer_deadline_heap dut (.*);

   initial begin
      forever #6 clock = ~clock;
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timer_deadline_heap: mismatch");
         $finish;
      end
   end

   function automatic void push_rsp(logic [STAT_W-1:0] st, int id, int rem, bit exp_f,
                                    bit last_f);
      rsp_beat_type b;
      b.status = st;
      b.result_id = id[IDX_W-1:0];
      b.remaining = rem[CNT_W-1:0];
      b.expired = exp_f;
      b.last = last_f;
      pending_rsp.push_back(b);
   endfunction

   function automatic void heap_swap(int h, int i, int j);
      logic [IDX_W-1:0] t;
      t = heap_mem[h][i];
      heap_mem[h][i] = heap_mem[h][j];
      heap_mem[h][j] = t;
   endfunction

   function automatic void sift_up(int h, int i);
      int p;
      while (i > 0) begin
         p = (i - 1) >> 1;
         if (due_at[heap_mem[h][p]] > due_at[heap_mem[h][i]]) begin
            heap_swap(h, p, i);
            i = p;
         end else break;
      end
   endfunction

   function automatic void sift_down(int h, int i);
      int l, r, son;
      forever begin
         l = 2 * i + 1;
         r = 2 * i + 2;
         son = (r < heap_cnt[h] && due_at[heap_mem[h][r]] < due_at[heap_mem[h][l]]) ? r : l;
         if (son < heap_cnt[h] && due_at[heap_mem[h][son]] < due_at[heap_mem[h][i]]) begin
            heap_swap(h, son, i);
            i = son;
         end else break;
      end
   endfunction

   function automatic void heap_push(int h, int id);
      if (heap_cnt[h] >= MAX_TIMERS) return;
      heap_mem[h][heap_cnt[h]] = id[IDX_W-1:0];
      heap_cnt[h]++;
      sift_up(h, heap_cnt[h] - 1);
   endfunction

   function automatic void heap_pop(int h);
      if (heap_cnt[h] == 0) return;
      heap_mem[h][0] = heap_mem[h][heap_cnt[h] - 1];
      heap_cnt[h]--;
      sift_down(h, 0);
   endfunction

   // Lift the slot to the root regardless of key, then pop it
   function automatic bit heap_remove(int h, int id);
      int pos, p;
      for (pos = 0; pos < heap_cnt[h]; pos++)
         if (heap_mem[h][pos] == id) break;
      if (pos >= heap_cnt[h]) return 1'b0;
      while (pos > 0) begin
         p = (pos - 1) >> 1;
         heap_swap(h, p, pos);
         pos = p;
      end
      heap_pop(h);
      return 1'b1;
   endfunction

   function automatic void disarm(int id);
      if (slot_st[id] != SLOT_RUNNING) return;
      if (!heap_remove(cur_heap, id)) void'(heap_remove(cur_heap ^ 1, id));
   endfunction

   function automatic void arm_slot(int id, int d);
      int sum;
      sum = now_tick + d;
      if (sum > TICK_MAX) begin
         due_at[id] = sum - TICK_MAX - 1;
         heap_push(cur_heap ^ 1, id);
      end else begin
         due_at[id] = sum;
         heap_push(cur_heap, id);
      end
      slot_st[id] = SLOT_RUNNING;
   endfunction

   function automatic void predict_tick();
      int n, id, sum;
      n = 0;
      now_tick = (now_tick + 1) & TICK_MAX;
      if (now_tick == 0) cur_heap ^= 1;
      while (n < MAX_TIMERS && heap_cnt[cur_heap] > 0 &&
             due_at[heap_mem[cur_heap][0]] <= now_tick) begin
         id = heap_mem[cur_heap][0];
         push_rsp(STAT_OK, id, 0, 1'b1, 1'b0);
         n++;
         if (reload_ticks[id] > 0) begin
            sum = now_tick + reload_ticks[id];
            if (sum > TICK_MAX) begin
               due_at[id] = sum - TICK_MAX - 1;
               heap_push(cur_heap ^ 1, id);
               heap_pop(cur_heap);
            end else begin
               due_at[id] = sum;
               sift_down(cur_heap, 0);
            end
         end else begin
            due_at[id] = 0;
            reload_ticks[id] = 0;
            slot_st[id] = SLOT_FREE;
            heap_pop(cur_heap);
         end
      end
      if (n > 0) pending_rsp[pending_rsp.size() - 1].last = 1'b1;
   endfunction

   function automatic void predict_command(logic [CMD_W-1:0] cmd, int id, int dly, int rld,
                                           bit del);
      bit known;
      int i, rem;
      known = slot_st[id] != SLOT_FREE;
      case (cmd)
         CMD_TICK: predict_tick();
         CMD_ALLOC: begin
            for (i = 0; i < MAX_TIMERS; i++)
               if (slot_st[i] == SLOT_FREE) break;
            if (i >= MAX_TIMERS) push_rsp(STAT_NOFREE, 0, 0, 1'b0, 1'b1);
            else begin
               slot_st[i] = SLOT_STOPPED;
               reload_ticks[i] = rld;
               due_at[i] = 0;
               if (dly > 0) arm_slot(i, dly);
               push_rsp(STAT_OK, i, 0, 1'b0, 1'b1);
            end
         end
         CMD_ARM: begin
            if (!known || dly == 0) push_rsp(STAT_BAD, id, 0, 1'b0, 1'b1);
            else begin
               disarm(id);
               reload_ticks[id] = rld;
               arm_slot(id, dly);
               push_rsp(STAT_OK, id, 0, 1'b0, 1'b1);
            end
         end
         CMD_STOP: begin
            if (!known) push_rsp(STAT_BAD, id, 0, 1'b0, 1'b1);
            else begin
               disarm(id);
               due_at[id] = 0;
               if (del) begin
                  slot_st[id] = SLOT_FREE;
                  reload_ticks[id] = 0;
               end else slot_st[id] = SLOT_STOPPED;
               push_rsp(STAT_OK, id, 0, 1'b0, 1'b1);
            end
         end
         CMD_READ: begin
            rem = 0;
            if (!known) push_rsp(STAT_BAD, id, 0, 1'b0, 1'b1);
            else begin
               if (slot_st[id] == SLOT_RUNNING)
                  rem = (due_at[id] >= now_tick) ? due_at[id] - now_tick
                                                 : TICK_MAX - now_tick + due_at[id] + 1;
               if (rem > TICK_MAX) rem = TICK_MAX;
               push_rsp(STAT_OK, id, rem, 1'b0, 1'b1);
            end
         end
         default: push_rsp(STAT_BAD, id, 0, 1'b0, 1'b1);
      endcase
   endfunction

   // Drive one beat, hold it until taken, then predict its results
   task automatic send_cmd(logic [CMD_W-1:0] cmd, int id, int dly, int rld, bit del);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_timer_id <= id[IDX_W-1:0];
      req_delay <= dly[CNT_W-1:0];
      req_reload <= rld[CNT_W-1:0];
      req_delete_flag <= del;
      do @(posedge clock); while (req_stall);
      predict_command(cmd, id, dly, rld, del);
   endtask

   task automatic drain();
      if (req_valid) req_valid <= 1'b0;
      while (pending_rsp.size() > 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   // Check each result beat against the oldest prediction
   always @(posedge clock) begin
      rsp_beat_type b;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rsp.size() == 0) begin
            $error("result beat with nothing expected");
            failed = 1'b1;
         end else begin
            b = pending_rsp.pop_front();
            if (rsp_status !== b.status) begin
               $error("status expected %0d actual %0d", b.status, rsp_status);
               failed = 1'b1;
            end
            if (rsp_result_id !== b.result_id) begin
               $error("result_id expected %0d actual %0d", b.result_id, rsp_result_id);
               failed = 1'b1;
            end
            if (rsp_remaining !== b.remaining) begin
               $error("remaining expected %0d actual %0d", b.remaining, rsp_remaining);
               failed = 1'b1;
            end
            if (rsp_expired !== b.expired) begin
               $error("expired expected %0d actual %0d", b.expired, rsp_expired);
               failed = 1'b1;
            end
            if (rsp_last !== b.last) begin
               $error("last expected %0d actual %0d", b.last, rsp_last);
               failed = 1'b1;
            end
         end
      end
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   task automatic test_basic_commands();
      send_cmd(CMD_ALLOC, 0, 0, 0, 0);
      send_cmd(CMD_READ, 0, 0, 0, 0);
      send_cmd(CMD_ALLOC, 9, 3, 2, 0);
      send_cmd(CMD_READ, 1, 0, 0, 0);
      send_cmd(CMD_ARM, 0, 0, 4, 0);
      send_cmd(CMD_ARM, 5, 7, 0, 0);
      send_cmd(CMD_ARM, 0, 5, 0, 0);
      send_cmd(CMD_ARM, 0, 6, 0, 0);
      send_cmd(CMD_STOP, 0, 0, 0, 0);
      send_cmd(CMD_STOP, 0, 0, 0, 1);
      send_cmd(CMD_STOP, 0, 0, 0, 0);
      send_cmd(CMD_READ, 0, 0, 0, 0);
      send_cmd(CMD_STOP, 15, 0, 0, 1);
      send_cmd(5, 3, 0, 0, 0);
      send_cmd(7, 15, 65535, 65535, 1);
      repeat (6) send_cmd(CMD_TICK, 0, 0, 0, 0);
      send_cmd(CMD_STOP, 1, 0, 0, 1);
      send_cmd(CMD_TICK, 0, 0, 0, 0);
   endtask

   // Fill every slot, one more is refused, then free them all
   task automatic test_slot_exhaustion();
      int i;
      for (i = 0; i < MAX_TIMERS; i++)
         send_cmd(CMD_ALLOC, 0, (i % 2) ? 65535 : 0, (i % 3) ? 65535 : 0, 0);
      send_cmd(CMD_ALLOC, 0, 1, 1, 0);
      send_cmd(CMD_READ, 1, 0, 0, 0);
      for (i = 0; i < MAX_TIMERS; i++) send_cmd(CMD_STOP, i, 0, 0, 1);
   endtask

   // Push one deadline past the counter top into the next-epoch heap, then tick and read
   task automatic test_counter_wrap();
      send_cmd(CMD_TICK, 0, 0, 0, 0);
      send_cmd(CMD_ALLOC, 0, 65535, 0, 0);
      send_cmd(CMD_ALLOC, 0, 4000, 4000, 0);
      send_cmd(CMD_ALLOC, 0, 65000, 30000, 0);
      send_cmd(CMD_READ, 0, 0, 0, 0);
      repeat (20) send_cmd(CMD_TICK, 0, 0, 0, 0);
      send_cmd(CMD_READ, 0, 0, 0, 0);
      send_cmd(CMD_READ, 2, 0, 0, 0);
      repeat (20) send_cmd(CMD_TICK, 0, 0, 0, 0);
      send_cmd(CMD_STOP, 0, 0, 0, 1);
      send_cmd(CMD_STOP, 1, 0, 0, 1);
      send_cmd(CMD_STOP, 2, 0, 0, 1);
   endtask

   function automatic int pick_timer();
      int i, base;
      if ($urandom_range(99) < 80) begin
         base = $urandom_range(MAX_TIMERS - 1);
         for (i = 0; i < MAX_TIMERS; i++)
            if (slot_st[(base + i) % MAX_TIMERS] != SLOT_FREE) return (base + i) % MAX_TIMERS;
      end
      return $urandom_range(MAX_TIMERS - 1);
   endfunction

   function automatic int pick_interval(int zero_pct);
      int r;
      r = $urandom_range(99);
      if (r < zero_pct) return 0;
      if (r < 88) return $urandom_range(1, 12);
      return $urandom_range(65535);
   endfunction

   task automatic test_random_mix(int items);
      int k, r;
      for (k = 0; k < items; k++) begin
         r = $urandom_range(99);
         if (r < 35) send_cmd(CMD_TICK, $urandom_range(15), $urandom_range(65535),
                              $urandom_range(65535), $urandom_range(1));
         else if (r < 50) send_cmd(CMD_ALLOC, $urandom_range(15), pick_interval(10),
                                   pick_interval(45), $urandom_range(1));
         else if (r < 70) send_cmd(CMD_ARM, pick_timer(), pick_interval(5),
                                   pick_interval(45), $urandom_range(1));
         else if (r < 85) send_cmd(CMD_STOP, pick_timer(), $urandom_range(65535),
                                   $urandom_range(65535), $urandom_range(1));
         else if (r < 97) send_cmd(CMD_READ, pick_timer(), 0, 0, 0);
         else send_cmd($urandom_range(5, 7), $urandom_range(15), 0, 0, 0);
      end
   endtask

   initial begin
      now_tick = 0;
      cur_heap = 0;
      heap_cnt[0] = 0;
      heap_cnt[1] = 0;
      for (int i = 0; i < MAX_TIMERS; i++) begin
         due_at[i] = 0;
         slot_st[i] = SLOT_FREE;
         reload_ticks[i] = 0;
      end
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_basic_commands();
      test_slot_exhaustion();
      drain();
      test_counter_wrap();
      drain();
      test_random_mix(50);
      sender_idle_pct = 67;
      test_random_mix(50);
      sender_idle_pct = 0;
      stall_pct = 67;
      test_random_mix(50);
      sender_idle_pct = 19;
      stall_pct = 19;
      test_random_mix(50);
      drain();
      stall_pct = 0;
      repeat (100) @(posedge clock);

      if (!failed && pending_rsp.size() == 0) $display("timer_deadline_heap: match");
      else $display("timer_deadline_heap: mismatch");
      $finish;
   end

endmodule

[sim.f]
+incdir+rtl
rtl/tdh_pkg.sv
rtl/tdh_heap.sv
rtl/timer_deadline_heap.sv
rtl/tdh_checker.sv
tb/timer_deadline_heap_tb.sv
